// ===== rtl/bmhq_pkg.sv =====
// Package for the binary min-heap queue: sizes, request and status codes,
// the datapath command set and the datapath status word. No dependencies.
package bmhq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int KEY_W    = 32;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
  localparam logic [OP_W-1:0] OP_REPLACE = 2'd2;
  localparam logic [OP_W-1:0] OP_SEARCH  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_POS   = 2'd3;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_INS_START,
    DP_RD_PARENT,
    DP_UP_MOVE,
    DP_WR_VAL,
    DP_RD_ENDS,
    DP_EX_SETUP,
    DP_RD_CHILD,
    DP_DN_MOVE,
    DP_REP_START,
    DP_LIFT_MOVE,
    DP_SCAN_START,
    DP_SCAN_STEP,
    DP_RD_ROOT,
    DP_CAPTURE
  } dp_cmd_t;

  typedef struct packed {
    logic            idx_zero;
    logic            up_less;
    logic            leaf;
    logic            dn_less;
    logic            cnt_one;
    logic            scan_end;
    logic            err;
    logic [OP_W-1:0] op;
  } dp_sts_t;

endpackage

// ===== rtl/bmhq_in_if.sv =====
// Request channel of the heap queue: valid/ready handshake and request word.
// Depends on bmhq_pkg.
interface bmhq_in_if;
  import bmhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [KEY_W-1:0] key_value;
  logic [IDX_W-1:0]        heap_position;

  modport source (output valid, output op, output key_value, output heap_position,
                  input ready);
  modport sink   (input valid, input op, input key_value, input heap_position,
                  output ready);
endinterface

// ===== rtl/bmhq_out_if.sv =====
// Result channel of the heap queue: valid/ready handshake and result word.
// Depends on bmhq_pkg.
interface bmhq_out_if;
  import bmhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] result_value;
  logic                    found;
  logic [STAT_W-1:0]       status;
  logic signed [KEY_W-1:0] min_value;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, output result_value, output found, output status,
                  output min_value, output entry_count, input ready);
  modport sink   (input valid, input result_value, input found, input status,
                  input min_value, input entry_count, output ready);
endinterface

// ===== rtl/bmhq_datapath.sv =====
// Datapath of the heap queue: heap memory with one write and two read ports,
// the sifting hole registers, the search counter and the result register.
// Depends on bmhq_pkg; driven by bmhq_ctrl through dp_cmd_t.
module bmhq_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bmhq_pkg::dp_cmd_t                cmd,
  output bmhq_pkg::dp_sts_t                sts,
  input  logic [bmhq_pkg::OP_W-1:0]        in_op,
  input  logic signed [bmhq_pkg::KEY_W-1:0] in_key_value,
  input  logic [bmhq_pkg::IDX_W-1:0]       in_heap_position,
  output logic signed [bmhq_pkg::KEY_W-1:0] out_result_value,
  output logic                             out_found,
  output logic [bmhq_pkg::STAT_W-1:0]      out_status,
  output logic signed [bmhq_pkg::KEY_W-1:0] out_min_value,
  output logic [bmhq_pkg::CNT_W-1:0]       out_entry_count
);
  import bmhq_pkg::*;

  logic signed [KEY_W-1:0] mem [CAPACITY];
  logic signed [KEY_W-1:0] rd0_r, rd1_r;

  logic [OP_W-1:0]         op_r;
  logic signed [KEY_W-1:0] key_r;
  logic [IDX_W-1:0]        pos_r;
  logic [IDX_W-1:0]        idx_r;
  logic signed [KEY_W-1:0] val_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [KEY_W-1:0] result_r;
  logic                    found_r;
  logic [STAT_W-1:0]       status_r;
  logic [CNT_W-1:0]        scan_r;
  logic                    scan_vld_r;

  logic signed [KEY_W-1:0] res_out_r, min_out_r;
  logic                    found_out_r;
  logic [STAT_W-1:0]       status_out_r;
  logic [CNT_W-1:0]        cnt_out_r;

  logic [IDX_W-1:0]        parent;
  logic [IDX_W+1:0]        lchild, rchild, cnt_ext;
  logic                    pick_r;
  logic signed [KEY_W-1:0] cval;
  logic [IDX_W-1:0]        cidx;
  logic                    re;
  logic [IDX_W-1:0]        ra0, ra1;
  logic                    we;
  logic [IDX_W-1:0]        wa;
  logic signed [KEY_W-1:0] wd;
  logic [STAT_W-1:0]       load_status;

  always_comb begin
    parent  = (idx_r - 1'b1) >> 1;
    lchild  = {1'b0, idx_r, 1'b1};
    rchild  = lchild + 1'b1;
    cnt_ext = {1'b0, cnt_r};
    pick_r  = (rchild < cnt_ext) && (rd1_r < rd0_r);
    cval    = pick_r ? rd1_r : rd0_r;
    cidx    = pick_r ? rchild[IDX_W-1:0] : lchild[IDX_W-1:0];
  end

  always_comb begin
    sts.idx_zero = (idx_r == '0);
    sts.up_less  = (val_r < rd0_r);
    sts.leaf     = (lchild >= cnt_ext);
    sts.dn_less  = (cval < val_r);
    sts.cnt_one  = (cnt_r == CNT_W'(1));
    sts.scan_end = (scan_r >= cnt_r) && !scan_vld_r;
    sts.err      = (status_r != ST_OK);
    sts.op       = op_r;
  end

  always_comb begin
    unique case (in_op)
      OP_INSERT:  load_status = (cnt_r >= CNT_W'(CAPACITY)) ? ST_FULL : ST_OK;
      OP_EXTRACT: load_status = (cnt_r == '0) ? ST_EMPTY : ST_OK;
      OP_REPLACE: load_status = ({1'b0, in_heap_position} >= cnt_r) ? ST_POS : ST_OK;
      default:    load_status = ST_OK;
    endcase
  end

  always_comb begin
    re  = 1'b0;
    ra0 = '0;
    ra1 = '0;
    we  = 1'b0;
    wa  = idx_r;
    wd  = val_r;
    unique case (cmd)
      DP_RD_PARENT: begin
        re  = 1'b1;
        ra0 = parent;
      end
      DP_RD_ENDS: begin
        re  = 1'b1;
        ra1 = IDX_W'(cnt_r - 1'b1);
      end
      DP_RD_CHILD: begin
        re  = 1'b1;
        ra0 = lchild[IDX_W-1:0];
        ra1 = rchild[IDX_W-1:0];
      end
      DP_SCAN_STEP: begin
        re  = (scan_r < cnt_r);
        ra0 = scan_r[IDX_W-1:0];
      end
      DP_RD_ROOT: re = 1'b1;
      DP_UP_MOVE, DP_LIFT_MOVE: begin
        we = 1'b1;
        wd = rd0_r;
      end
      DP_DN_MOVE: begin
        we = 1'b1;
        wd = cval;
      end
      DP_WR_VAL: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd0_r <= mem[ra0];
      rd1_r <= mem[ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      scan_vld_r <= 1'b0;
    end else begin
      unique case (cmd)
        DP_LOAD: begin
          op_r     <= in_op;
          key_r    <= in_key_value;
          pos_r    <= in_heap_position;
          result_r <= '0;
          found_r  <= 1'b0;
          status_r <= load_status;
        end
        DP_INS_START: begin
          idx_r <= cnt_r[IDX_W-1:0];
          val_r <= key_r;
          cnt_r <= cnt_r + 1'b1;
        end
        DP_UP_MOVE, DP_LIFT_MOVE: idx_r <= parent;
        DP_DN_MOVE: idx_r <= cidx;
        DP_EX_SETUP: begin
          if (op_r == OP_EXTRACT) begin
            result_r <= rd0_r;
          end
          val_r <= rd1_r;
          cnt_r <= cnt_r - 1'b1;
          idx_r <= '0;
        end
        DP_REP_START: idx_r <= pos_r;
        DP_SCAN_START: begin
          scan_r     <= '0;
          scan_vld_r <= 1'b0;
        end
        DP_SCAN_STEP: begin
          if (scan_vld_r && (rd0_r == key_r)) begin
            found_r <= 1'b1;
          end
          if (scan_r < cnt_r) begin
            scan_r     <= scan_r + 1'b1;
            scan_vld_r <= 1'b1;
          end else begin
            scan_vld_r <= 1'b0;
          end
        end
        DP_CAPTURE: begin
          res_out_r    <= result_r;
          found_out_r  <= found_r;
          status_out_r <= status_r;
          min_out_r    <= (cnt_r != '0) ? rd0_r : '0;
          cnt_out_r    <= cnt_r;
        end
        default: ;
      endcase
    end
  end

  assign out_result_value = res_out_r;
  assign out_found        = found_out_r;
  assign out_status       = status_out_r;
  assign out_min_value    = min_out_r;
  assign out_entry_count  = cnt_out_r;

endmodule

// ===== rtl/bmhq_ctrl.sv =====
// Controller of the heap queue: sequences sift-up, sift-down, lift and search
// passes and owns both handshakes. Depends on bmhq_pkg; drives bmhq_datapath.
module bmhq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bmhq_pkg::dp_sts_t    sts,
  output bmhq_pkg::dp_cmd_t    cmd
);
  import bmhq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_INS     = 4'd2;
  localparam logic [3:0] S_UP      = 4'd3;
  localparam logic [3:0] S_UP_CMP  = 4'd4;
  localparam logic [3:0] S_EX1     = 4'd5;
  localparam logic [3:0] S_DN      = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_LIFT    = 4'd8;
  localparam logic [3:0] S_LIFT_WR = 4'd9;
  localparam logic [3:0] S_SCAN    = 4'd10;
  localparam logic [3:0] S_MIN     = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] after_dn;

  assign after_dn  = (sts.op == OP_REPLACE) ? S_INS : S_MIN;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = DP_NOP;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = DP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.err) begin
          state_nxt = S_MIN;
        end else begin
          unique case (sts.op)
            OP_INSERT: begin
              cmd       = DP_INS_START;
              state_nxt = S_UP;
            end
            OP_EXTRACT: begin
              cmd       = DP_RD_ENDS;
              state_nxt = S_EX1;
            end
            OP_REPLACE: begin
              cmd       = DP_REP_START;
              state_nxt = S_LIFT;
            end
            default: begin
              cmd       = DP_SCAN_START;
              state_nxt = S_SCAN;
            end
          endcase
        end
      end
      S_INS: begin
        cmd       = DP_INS_START;
        state_nxt = S_UP;
      end
      S_UP: begin
        if (sts.idx_zero) begin
          cmd       = DP_WR_VAL;
          state_nxt = S_MIN;
        end else begin
          cmd       = DP_RD_PARENT;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_less) begin
          cmd       = DP_UP_MOVE;
          state_nxt = S_UP;
        end else begin
          cmd       = DP_WR_VAL;
          state_nxt = S_MIN;
        end
      end
      S_EX1: begin
        cmd       = DP_EX_SETUP;
        state_nxt = sts.cnt_one ? after_dn : S_DN;
      end
      S_DN: begin
        if (sts.leaf) begin
          cmd       = DP_WR_VAL;
          state_nxt = after_dn;
        end else begin
          cmd       = DP_RD_CHILD;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.dn_less) begin
          cmd       = DP_DN_MOVE;
          state_nxt = S_DN;
        end else begin
          cmd       = DP_WR_VAL;
          state_nxt = after_dn;
        end
      end
      S_LIFT: begin
        if (sts.idx_zero) begin
          cmd       = DP_RD_ENDS;
          state_nxt = S_EX1;
        end else begin
          cmd       = DP_RD_PARENT;
          state_nxt = S_LIFT_WR;
        end
      end
      S_LIFT_WR: begin
        cmd       = DP_LIFT_MOVE;
        state_nxt = S_LIFT;
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_MIN;
        end else begin
          cmd = DP_SCAN_STEP;
        end
      end
      S_MIN: begin
        cmd       = DP_RD_ROOT;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd           = DP_CAPTURE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/binary_min_heap_queue.sv =====
// Binary min-heap priority queue of 64 signed 32-bit keys, one request at a
// time. Insert sifts the new key up level by level; extract moves the last
// entry to the root and sifts it down; replace lifts the entry at the given
// position to the root, then does a descent and an insert; search scans the
// stored entries in turn. Each sift-up or sift-down level costs a registered
// memory read followed by a compare and write; a lift level costs a read and
// a write. A new request is taken while the previous result still waits in the output register.
// Depends on bmhq_pkg, bmhq_in_if, bmhq_out_if, bmhq_ctrl and bmhq_datapath.
module binary_min_heap_queue (
  input  logic        clk,
  input  logic        rst_n,
  bmhq_in_if.sink     in_s,
  bmhq_out_if.source  out_s
);
  import bmhq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmhq_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_s.op),
    .in_key_value     (in_s.key_value),
    .in_heap_position (in_s.heap_position),
    .out_result_value (out_s.result_value),
    .out_found        (out_s.found),
    .out_status       (out_s.status),
    .out_min_value    (out_s.min_value),
    .out_entry_count  (out_s.entry_count)
  );

endmodule
